// ===== rtl/ansdet_pkg.sv =====
// package with event codes, verdict and cause codes and register defaults for the detector
package ansdet_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_FRAME   = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_HANGUP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_MACHINE = 2'd0,
    VERDICT_HUMAN   = 2'd1,
    VERDICT_NOTSURE = 2'd2,
    VERDICT_HANGUP  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    CAUSE_TOO_LONG      = 3'd0,
    CAUSE_INIT_SILENCE  = 3'd1,
    CAUSE_HUMAN_SILENCE = 3'd2,
    CAUSE_MAX_WORDS     = 3'd3,
    CAUSE_LONG_GREETING = 3'd4,
    CAUSE_MAX_WORD_LEN  = 3'd5,
    CAUSE_HANGUP        = 3'd6
  } cause_t;

  typedef enum logic [2:0] {
    REG_INIT_SILENCE  = 3'd0,
    REG_GREETING      = 3'd1,
    REG_AFTER_GREET   = 3'd2,
    REG_TOTAL_LIMIT   = 3'd3,
    REG_MIN_WORD      = 3'd4,
    REG_BETWEEN_WORDS = 3'd5,
    REG_MAX_WORDS     = 3'd6,
    REG_MAX_WORD_LEN  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] detail;
    cause_t      cause;
    verdict_t    verdict;
  } result_t;

  localparam logic [15:0] INIT_SILENCE_RST  = 16'd2500;
  localparam logic [15:0] GREETING_RST      = 16'd1500;
  localparam logic [15:0] AFTER_GREET_RST   = 16'd800;
  localparam logic [15:0] TOTAL_LIMIT_RST   = 16'd5000;
  localparam logic [15:0] MIN_WORD_RST      = 16'd100;
  localparam logic [15:0] BETWEEN_WORDS_RST = 16'd50;
  localparam logic [7:0]  MAX_WORDS_RST     = 8'd3;
  localparam logic [15:0] MAX_WORD_LEN_RST  = 16'd5000;

endpackage

// ===== rtl/answering_machine_detector_unit.sv =====
// top level of the call-start detector: event decode, counters, decision and output skid
//
//  port group | dir | tdata (low bit up)                          | tuser
//  in_        | in  | frame_ms[7:0], silence_ms[23:8]             | operation[1:0]
//  out_       | out | verdict[1:0], cause[4:2], detail[20:5], pad | -
//  cfg_       | in  | write enable, 3-bit index, 16-bit data      | -
//
// one word per cycle while in_tready is high; each word is processed in the cycle it is accepted
// a decision is registered into the out_ register, or into the skid entry while out_ is stalled
// out_ has a register plus one skid entry; in_tready drops only while the skid is full
// synchronous active-low reset restores register defaults and opens a new call
module answering_machine_detector_unit
  import ansdet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // frame_ms, silence_ms
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // verdict, cause, detail, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] init_sil_lim_r, greet_lim_r, after_greet_r, total_lim_r;
  logic [15:0] min_word_r, between_words_r, max_word_len_r;
  logic [7:0]  max_words_r;

  logic [15:0] total_r, total_nxt, voice_r, voice_nxt, cons_r, cons_nxt;
  logic [7:0]  words_r, words_nxt;
  logic        init_r, init_nxt, greet_r, greet_nxt, in_word_r, in_word_nxt;
  logic        decided_r, decided_nxt;

  logic        out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  result_t     out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;

  logic        in_fire, res_v;
  result_t     res;
  op_t         op;
  logic [7:0]  frame_ms;
  logic [15:0] silence_ms;
  logic [16:0] total_sum, voice_sum, cons_sum;
  logic [15:0] total_sat, voice_sat, cons_sat;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign op         = op_t'(in_tuser);
  assign frame_ms   = in_tdata[7:0];
  assign silence_ms = in_tdata[23:8];

  assign total_sum = {1'b0, total_r} + {9'd0, frame_ms};
  assign voice_sum = {1'b0, voice_r} + {9'd0, frame_ms};
  assign cons_sum  = {1'b0, cons_r} + {9'd0, frame_ms};
  assign total_sat = total_sum[16] ? 16'hFFFF : total_sum[15:0];
  assign voice_sat = voice_sum[16] ? 16'hFFFF : voice_sum[15:0];
  assign cons_sat  = cons_sum[16] ? 16'hFFFF : cons_sum[15:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_sil_lim_r  <= INIT_SILENCE_RST;
      greet_lim_r     <= GREETING_RST;
      after_greet_r   <= AFTER_GREET_RST;
      total_lim_r     <= TOTAL_LIMIT_RST;
      min_word_r      <= MIN_WORD_RST;
      between_words_r <= BETWEEN_WORDS_RST;
      max_words_r     <= MAX_WORDS_RST;
      max_word_len_r  <= MAX_WORD_LEN_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_INIT_SILENCE:  init_sil_lim_r  <= cfg_wdata;
        REG_GREETING:      greet_lim_r     <= cfg_wdata;
        REG_AFTER_GREET:   after_greet_r   <= cfg_wdata;
        REG_TOTAL_LIMIT:   total_lim_r     <= cfg_wdata;
        REG_MIN_WORD:      min_word_r      <= cfg_wdata;
        REG_BETWEEN_WORDS: between_words_r <= cfg_wdata;
        REG_MAX_WORDS:     max_words_r     <= cfg_wdata[7:0];
        REG_MAX_WORD_LEN:  max_word_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-call state update and decision
  always_comb begin
    total_nxt   = total_r;
    voice_nxt   = voice_r;
    cons_nxt    = cons_r;
    words_nxt   = words_r;
    init_nxt    = init_r;
    greet_nxt   = greet_r;
    in_word_nxt = in_word_r;
    decided_nxt = decided_r;
    res_v       = 1'b0;
    res.verdict = VERDICT_NOTSURE;
    res.cause   = CAUSE_TOO_LONG;
    res.detail  = total_r;
    if (in_fire) begin
      unique case (op)
        OP_START: begin
          total_nxt   = '0;
          voice_nxt   = '0;
          cons_nxt    = '0;
          words_nxt   = '0;
          init_nxt    = 1'b1;
          greet_nxt   = 1'b0;
          in_word_nxt = 1'b0;
          decided_nxt = 1'b0;
        end
        OP_HANGUP: begin
          if (!decided_r) begin
            res_v       = 1'b1;
            res.verdict = VERDICT_HANGUP;
            res.cause   = CAUSE_HANGUP;
            res.detail  = '0;
          end
        end
        OP_TIMEOUT: begin
          res_v = !decided_r;
        end
        OP_FRAME: begin
          if (!decided_r) begin
            total_nxt = total_sat;
            if (total_sat >= total_lim_r) begin
              res_v      = 1'b1;
              res.detail = total_sat;
            end else if (silence_ms != '0) begin
              if (silence_ms >= between_words_r) begin
                in_word_nxt = 1'b0;
                cons_nxt    = '0;
              end
              if (init_r && silence_ms >= init_sil_lim_r) begin
                res_v       = 1'b1;
                res.verdict = VERDICT_MACHINE;
                res.cause   = CAUSE_INIT_SILENCE;
                res.detail  = silence_ms;
              end else if (greet_r && silence_ms >= after_greet_r) begin
                res_v       = 1'b1;
                res.verdict = VERDICT_HUMAN;
                res.cause   = CAUSE_HUMAN_SILENCE;
                res.detail  = silence_ms;
              end
            end else begin
              cons_nxt  = cons_sat;
              voice_nxt = voice_sat;
              if (cons_sat >= min_word_r && !in_word_r) begin
                words_nxt   = (words_r == 8'hFF) ? words_r : words_r + 8'd1;
                in_word_nxt = 1'b1;
              end
              if (cons_sat >= max_word_len_r) begin
                res_v       = 1'b1;
                res.verdict = VERDICT_MACHINE;
                res.cause   = CAUSE_MAX_WORD_LEN;
                res.detail  = cons_sat;
              end else if (words_nxt >= max_words_r) begin
                res_v       = 1'b1;
                res.verdict = VERDICT_MACHINE;
                res.cause   = CAUSE_MAX_WORDS;
                res.detail  = {8'd0, words_nxt};
              end else if (greet_r && voice_sat >= greet_lim_r) begin
                res_v       = 1'b1;
                res.verdict = VERDICT_MACHINE;
                res.cause   = CAUSE_LONG_GREETING;
                res.detail  = voice_sat;
              end else if (cons_sat >= min_word_r && !greet_r) begin
                init_nxt  = 1'b0;
                greet_nxt = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      if (res_v) begin
        decided_nxt = 1'b1;
      end
    end
  end

  // output register with one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_v;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = res_v;
        out_data_nxt  = res;
      end
    end else if (res_v) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      voice_r      <= '0;
      cons_r       <= '0;
      words_r      <= '0;
      init_r       <= 1'b1;
      greet_r      <= 1'b0;
      in_word_r    <= 1'b0;
      decided_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      total_r      <= total_nxt;
      voice_r      <= voice_nxt;
      cons_r       <= cons_nxt;
      words_r      <= words_nxt;
      init_r       <= init_nxt;
      greet_r      <= greet_nxt;
      in_word_r    <= in_word_nxt;
      decided_r    <= decided_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_decision_latches: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |=> decided_r)
    else $error("decision given but call not closed");

  a_one_per_call: assert property (@(posedge clk) disable iff (!rst_n)
    (decided_r && !(in_fire && op == OP_START)) |-> !res_v)
    else $error("second decision in one call");

  a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(init_r && greet_r))
    else $error("initial silence and greeting both set");

endmodule

// ===== verif/answering_machine_detector_unit_test.sv =====
// self-checking testbench for the call-start detector, with its own predictor of the decisions
module answering_machine_detector_unit_test;
  import ansdet_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 300;

  typedef struct {
    op_t         op;
    logic [7:0]  frame_ms;
    logic [15:0] silence_ms;
  } call_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // frame_ms, silence_ms
  logic [1:0]  in_tuser = '0;   // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // verdict, cause, detail, zero pad
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  answering_machine_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  call_event_t event_q[$];
  result_t     decision_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          stall_asked = 0;
  int          stall_served = 0;
  int          stall_left = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          queued = 0;

  // predictor state: thresholds and the open call
  logic [15:0] thresh [0:7] = '{INIT_SILENCE_RST, GREETING_RST, AFTER_GREET_RST,
                                TOTAL_LIMIT_RST, MIN_WORD_RST, BETWEEN_WORDS_RST,
                                {8'd0, MAX_WORDS_RST}, MAX_WORD_LEN_RST};
  logic [15:0] tot_ms = '0;
  logic [15:0] voice_ms = '0;
  logic [15:0] run_ms = '0;
  logic [7:0]  words = '0;
  logic        in_init_sil = 1'b1;
  logic        in_greet = 1'b0;
  logic        in_word_f = 1'b0;
  logic        call_done = 1'b0;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  function automatic result_t mk(input verdict_t v, input cause_t c, input logic [15:0] d);
    result_t r;
    r.verdict = v;
    r.cause   = c;
    r.detail  = d;
    return r;
  endfunction

  function automatic bit classify(input op_t op, input logic [7:0] frame_ms,
                                  input logic [15:0] silence_ms, output result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (op == OP_START) begin
      tot_ms = '0;
      voice_ms = '0;
      run_ms = '0;
      words = '0;
      in_init_sil = 1'b1;
      in_greet = 1'b0;
      in_word_f = 1'b0;
      call_done = 1'b0;
    end else if (!call_done) begin
      hit = 1'b1;
      if (op == OP_HANGUP) begin
        res = mk(VERDICT_HANGUP, CAUSE_HANGUP, 16'd0);
      end else if (op == OP_TIMEOUT) begin
        res = mk(VERDICT_NOTSURE, CAUSE_TOO_LONG, tot_ms);
      end else begin
        tot_ms = sat_add(tot_ms, frame_ms);
        if (tot_ms >= thresh[REG_TOTAL_LIMIT]) begin
          res = mk(VERDICT_NOTSURE, CAUSE_TOO_LONG, tot_ms);
        end else if (silence_ms != 16'd0) begin
          if (silence_ms >= thresh[REG_BETWEEN_WORDS]) begin
            in_word_f = 1'b0;
            run_ms = '0;
          end
          if (in_init_sil && silence_ms >= thresh[REG_INIT_SILENCE])
            res = mk(VERDICT_MACHINE, CAUSE_INIT_SILENCE, silence_ms);
          else if (in_greet && silence_ms >= thresh[REG_AFTER_GREET])
            res = mk(VERDICT_HUMAN, CAUSE_HUMAN_SILENCE, silence_ms);
          else
            hit = 1'b0;
        end else begin
          run_ms = sat_add(run_ms, frame_ms);
          voice_ms = sat_add(voice_ms, frame_ms);
          if (run_ms >= thresh[REG_MIN_WORD] && !in_word_f) begin
            if (words != 8'hff) words = words + 8'd1;
            in_word_f = 1'b1;
          end
          if (run_ms >= thresh[REG_MAX_WORD_LEN]) begin
            res = mk(VERDICT_MACHINE, CAUSE_MAX_WORD_LEN, run_ms);
          end else if (words >= thresh[REG_MAX_WORDS][7:0]) begin
            res = mk(VERDICT_MACHINE, CAUSE_MAX_WORDS, {8'd0, words});
          end else if (in_greet && voice_ms >= thresh[REG_GREETING]) begin
            res = mk(VERDICT_MACHINE, CAUSE_LONG_GREETING, voice_ms);
          end else begin
            hit = 1'b0;
            if (run_ms >= thresh[REG_MIN_WORD] && !in_greet) begin
              in_init_sil = 1'b0;
              in_greet = 1'b1;
            end
          end
        end
      end
      call_done = hit;
    end
    return hit;
  endfunction

  // driver
  always @(posedge clk) begin
    call_event_t ev;
    result_t     r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (classify(op_t'(in_tuser), in_tdata[7:0], in_tdata[23:8], r))
          decision_q.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = event_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {ev.silence_ms, ev.frame_ms};
          in_tuser <= ev.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_served != stall_asked) begin
      stall_served <= stall_asked;
      stall_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decision_q.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected result word %h", out_tdata);
        fail_cnt++;
      end else begin
        want = decision_q.pop_front();
        if (out_tdata[1:0] !== want.verdict || out_tdata[4:2] !== want.cause ||
            out_tdata[20:5] !== want.detail) begin
          if (fail_cnt < 10)
            $display("expected verdict %0d cause %0d detail %0d, got %0d %0d %0d",
                     want.verdict, want.cause, want.detail,
                     out_tdata[1:0], out_tdata[4:2], out_tdata[20:5]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("answering_machine_detector_unit: mismatch");
      $finish;
    end
  end

  task automatic push(input op_t op, input logic [7:0] f, input logic [15:0] s);
    call_event_t ev;
    ev.op = op;
    ev.frame_ms = f;
    ev.silence_ms = s;
    event_q.push_back(ev);
    queued++;
  endtask

  task automatic drain();
    while (event_q.size() != 0 || in_tvalid || decision_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    thresh[idx] = (idx == REG_MAX_WORDS) ? {8'd0, val[7:0]} : val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input int mode);
    logic [15:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = (i == REG_MAX_WORDS) ? {8'd0, MAX_WORDS_RST} :
               (i == REG_INIT_SILENCE) ? INIT_SILENCE_RST :
               (i == REG_GREETING) ? GREETING_RST :
               (i == REG_AFTER_GREET) ? AFTER_GREET_RST :
               (i == REG_TOTAL_LIMIT) ? TOTAL_LIMIT_RST :
               (i == REG_MIN_WORD) ? MIN_WORD_RST :
               (i == REG_BETWEEN_WORDS) ? BETWEEN_WORDS_RST : MAX_WORD_LEN_RST;
        1: v = (i == REG_MAX_WORDS) ? 16'($urandom_range(1, 6)) : 16'($urandom_range(0, 400));
        2: v = 16'd0;
        3: v = 16'hffff;
        4: v = (i == REG_MAX_WORDS) ? 16'($urandom_range(1, 8))
                                    : 16'($urandom_range(50, 3000));
        default: begin
          case ($urandom_range(0, 2))
            0: v = 16'd0;
            1: v = 16'hffff;
            default: v = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      write_reg(reg_idx_t'(i), v);
    end
  endtask

  function automatic logic [7:0] pick_frame();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(5, 80));
    endcase
  endfunction

  // one call: start, then runs of voice and silence, now and then a stray word
  task automatic add_call();
    int          segs;
    int          len;
    logic [7:0]  f;
    logic [15:0] s;
    push(OP_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    segs = $urandom_range(1, 12);
    for (int k = 0; k < segs; k++) begin
      len = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int j = 0; j < len; j++) push(OP_FRAME, pick_frame(), 16'd0);
        end
        4, 5, 6, 7: begin
          s = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
          for (int j = 0; j < len; j++) begin
            f = pick_frame();
            s = sat_add(s, f);
            push(OP_FRAME, f, s);
          end
        end
        8: push($urandom_range(0, 1) ? OP_TIMEOUT : OP_HANGUP,
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        default: push(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
      endcase
    end
  endtask

  initial begin
    int modes [0:7];
    modes = '{4, 1, 2, 3, 5, 4, 1, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset thresholds, call open without a start
    push(OP_FRAME, 8'd0, 16'd0);
    push(OP_TIMEOUT, 8'd0, 16'd0);
    push(OP_HANGUP, 8'd255, 16'hffff);
    push(OP_FRAME, 8'd255, 16'hffff);
    push(OP_START, 8'd255, 16'hffff);
    push(OP_FRAME, 8'd20, 16'd2500);
    push(OP_START, 8'd0, 16'd0);
    push(OP_HANGUP, 8'd0, 16'd0);
    push(OP_START, 8'd0, 16'd0);
    push(OP_FRAME, 8'd255, 16'd0);
    push(OP_FRAME, 8'd200, 16'd800);
    push(OP_START, 8'd0, 16'd0);
    for (int i = 0; i < 6; i++) push(OP_FRAME, 8'd255, 16'd0);
    push(OP_START, 8'd0, 16'd0);
    push(OP_FRAME, 8'd150, 16'd0);
    push(OP_FRAME, 8'd10, 16'd60);
    push(OP_FRAME, 8'd150, 16'd0);
    push(OP_FRAME, 8'd10, 16'd60);
    push(OP_FRAME, 8'd150, 16'd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_limits(modes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (modes[p] == 3) begin
        // total time saturates and so reaches the analysis limit
        push(OP_START, 8'd0, 16'd0);
        for (int i = 0; i < 260; i++) push(OP_FRAME, 8'd255, 16'd0);
      end
      queued = 0;
      while (queued < 125) add_call();
      drain();
    end

    // long receiver hold while hangups keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_asked = stall_asked + 1;
    for (int i = 0; i < 40; i++) begin
      push(OP_HANGUP, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      push(OP_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
    drain();

    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && decision_q.size() == 0) begin
      $display("answering_machine_detector_unit: match");
    end else begin
      $display("answering_machine_detector_unit: mismatch");
    end
    $finish;
  end

endmodule
